>>> src/pqus_pkg.sv
package pqus_pkg;

   // Field widths of the request and result beats.
   localparam int OP_W = 2;
   localparam int TAG_W = 16;
   localparam int PRIO_W = 3;
   localparam int STATUS_W = 3;
   localparam int COUNT_W = 6;

   localparam int REQ_FIELDS_W = OP_W + TAG_W + PRIO_W;
   localparam int REQ_TDATA_W = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = STATUS_W + TAG_W + PRIO_W + 2 * COUNT_W;
   localparam int RSP_TDATA_W = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W = RSP_TDATA_W - RSP_FIELDS_W;

   // Bit positions inside req_tdata.
   localparam int REQ_OP_LSB = 0;
   localparam int REQ_TAG_LSB = REQ_OP_LSB + OP_W;
   localparam int REQ_PRIO_LSB = REQ_TAG_LSB + TAG_W;

   // Bit positions inside rsp_tdata.
   localparam int RSP_STATUS_LSB = 0;
   localparam int RSP_TAG_LSB = RSP_STATUS_LSB + STATUS_W;
   localparam int RSP_PRIO_LSB = RSP_TAG_LSB + TAG_W;
   localparam int RSP_PCOUNT_LSB = RSP_PRIO_LSB + PRIO_W;
   localparam int RSP_CCOUNT_LSB = RSP_PCOUNT_LSB + COUNT_W;

   localparam logic [PRIO_W-1:0] MAX_PRIORITY = 3'd5;

   localparam int DEF_PENDING_DEPTH = 32;
   localparam int DEF_COMPLETED_DEPTH = 32;
   localparam int DEF_TAG_BITS = 16;

   typedef enum logic [OP_W-1:0] {
      OP_ADD     = 2'd0,
      OP_PROCESS = 2'd1,
      OP_UNDO    = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK           = 3'd0,
      ST_DEQUE_EMPTY  = 3'd1,
      ST_STACK_EMPTY  = 3'd2,
      ST_DEQUE_FULL   = 3'd3,
      ST_STACK_FULL   = 3'd4,
      ST_BAD_PRIORITY = 3'd5
   } status_type;

   // Where the entry reported by a result comes from.
   typedef enum logic [1:0] {
      SRC_NONE = 2'd0,
      SRC_REQ  = 2'd1,
      SRC_PEND = 2'd2,
      SRC_COMP = 2'd3
   } src_type;

endpackage

>>> src/pqus_ram.sv
module pqus_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 19,
   parameter int AW = 5
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read returns the contents before a write at the same edge.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/pending_queue_with_undo_stack.sv
// Channel  Direction  Handshake              tdata fields, lowest bit first
// req      in         req_tvalid/req_tready  operation, task_tag, priority_req
// rsp      out        rsp_tvalid/rsp_tready  status, moved_tag, moved_priority,
//                                            pending_count, completed_count
//
// One request beat is taken every cycle while req_tready is high; its result goes
// through the middle stage and the result register to rsp. The occupancy and
// pointer registers are updated at acceptance, the store read happens at that
// edge and the store write one stage later. Reset is synchronous and empties
// both the deque and the stack at once. With rsp_tready low the block still
// takes one more beat, then holds req_tready low until the result register drains.
module pending_queue_with_undo_stack
   import pqus_pkg::*;
#(
   parameter int PENDING_DEPTH = DEF_PENDING_DEPTH,
   parameter int COMPLETED_DEPTH = DEF_COMPLETED_DEPTH,
   parameter int TAG_BITS = DEF_TAG_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // operation[1:0], task_tag[17:2], priority_req[20:18], zero fill
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // status[2:0], moved_tag[18:3], moved_priority[21:19],
   // pending_count[27:22], completed_count[33:28], zero fill
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int PAW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
   localparam int PSW = PAW + 1;
   localparam int PCW = $clog2(PENDING_DEPTH + 1);
   localparam int CAW = (COMPLETED_DEPTH > 1) ? $clog2(COMPLETED_DEPTH) : 1;
   localparam int CCW = $clog2(COMPLETED_DEPTH + 1);
   localparam int EW = TAG_BITS + PRIO_W;

   localparam logic [PAW-1:0] PLAST = PAW'(PENDING_DEPTH - 1);
   localparam logic [PCW-1:0] PFULL = PCW'(PENDING_DEPTH);
   localparam logic [PSW-1:0] PWRAP = PSW'(PENDING_DEPTH);
   localparam logic [CCW-1:0] CFULL = CCW'(COMPLETED_DEPTH);

   // Architectural state.
   logic [PAW-1:0] head_ff, head_in;
   logic [PCW-1:0] pocc_ff, pocc_in;
   logic [CCW-1:0] cocc_ff, cocc_in;

   // Decision for the beat at the input.
   op_type            op;
   logic [31:0]       tag_wide;
   logic [TAG_BITS-1:0] in_tag;
   logic [PRIO_W-1:0] in_prio;
   status_type        d_status;
   src_type           d_src;
   logic              d_pend_we;
   logic [PAW-1:0]    d_pend_waddr;
   logic              d_comp_we;
   logic [CAW-1:0]    d_comp_waddr;
   logic [PSW-1:0]    tail_sum;
   logic [PAW-1:0]    tail;
   logic [PAW-1:0]    head_inc;
   logic [PAW-1:0]    head_dec;
   logic [CAW-1:0]    comp_raddr;
   logic              fwd_hit;
   logic              accept;

   // Middle stage: the decided beat waits here for its store read data.
   logic              b_valid_ff, b_valid_in;
   status_type        b_status_ff;
   src_type           b_src_ff;
   logic [EW-1:0]     b_req_entry_ff;
   logic              b_pend_we_ff;
   logic [PAW-1:0]    b_pend_waddr_ff;
   logic              b_comp_we_ff;
   logic [CAW-1:0]    b_comp_waddr_ff;
   logic              b_fwd_ff;
   logic [EW-1:0]     b_fwd_data_ff;
   logic [PCW-1:0]    b_pocc_ff;
   logic [CCW-1:0]    b_cocc_ff;
   logic              b_adv;
   logic [EW-1:0]     b_read_val;
   logic [EW-1:0]     b_moved;

   logic [EW-1:0]     pend_rd_data;
   logic [EW-1:0]     comp_rd_data;

   // Result register.
   logic                   o_valid_ff, o_valid_in;
   logic [RSP_TDATA_W-1:0] o_data_ff;
   logic [RSP_TDATA_W-1:0] o_data_in;
   logic [31:0]            out_tag_wide;
   logic [31:0]            out_pcount_wide;
   logic [31:0]            out_ccount_wide;
   logic [TAG_BITS-1:0]    moved_tag_trim;

   assign op = op_type'(req_tdata[REQ_OP_LSB +: OP_W]);
   assign tag_wide = 32'(req_tdata[REQ_TAG_LSB +: TAG_W]);
   assign in_tag = tag_wide[TAG_BITS-1:0];
   assign in_prio = req_tdata[REQ_PRIO_LSB +: PRIO_W];

   assign tail_sum = PSW'(head_ff) + PSW'(pocc_ff);
   assign tail = (tail_sum >= PWRAP) ? PAW'(tail_sum - PWRAP) : PAW'(tail_sum);
   assign head_inc = (head_ff == PLAST) ? '0 : head_ff + PAW'(1);
   assign head_dec = (head_ff == '0) ? PLAST : head_ff - PAW'(1);
   assign comp_raddr = CAW'(cocc_ff - CCW'(1));

   always_comb begin
      d_status = ST_OK;
      d_src = SRC_NONE;
      d_pend_we = 1'b0;
      d_pend_waddr = tail;
      d_comp_we = 1'b0;
      d_comp_waddr = CAW'(cocc_ff);
      head_in = head_ff;
      pocc_in = pocc_ff;
      cocc_in = cocc_ff;
      case (op)
         OP_ADD: begin
            if (in_prio > MAX_PRIORITY) begin
               d_status = ST_BAD_PRIORITY;
            end else if (pocc_ff == PFULL) begin
               d_status = ST_DEQUE_FULL;
            end else begin
               d_src = SRC_REQ;
               d_pend_we = 1'b1;
               pocc_in = pocc_ff + PCW'(1);
            end
         end
         OP_PROCESS: begin
            if (pocc_ff == '0) begin
               d_status = ST_DEQUE_EMPTY;
            end else if (cocc_ff == CFULL) begin
               d_status = ST_STACK_FULL;
            end else begin
               d_src = SRC_PEND;
               d_comp_we = 1'b1;
               head_in = head_inc;
               pocc_in = pocc_ff - PCW'(1);
               cocc_in = cocc_ff + CCW'(1);
            end
         end
         OP_UNDO: begin
            if (cocc_ff == '0) begin
               d_status = ST_STACK_EMPTY;
            end else if (pocc_ff == PFULL) begin
               d_status = ST_DEQUE_FULL;
            end else begin
               d_src = SRC_COMP;
               d_pend_we = 1'b1;
               d_pend_waddr = head_dec;
               head_in = head_dec;
               pocc_in = pocc_ff + PCW'(1);
               cocc_in = cocc_ff - CCW'(1);
            end
         end
         default: begin
            d_status = ST_OK;
         end
      endcase
   end

   // The middle stage moves on when the result register is free or draining.
   assign b_adv = b_valid_ff && (!o_valid_ff || rsp_tready);
   assign req_tready = !b_valid_ff || b_adv;
   assign accept = req_tvalid && req_tready;

   // The write of the beat leaving the middle stage lands at the same edge as
   // this read, so a matching address takes the data straight across.
   always_comb begin
      fwd_hit = 1'b0;
      if (b_adv) begin
         if (d_src == SRC_PEND) begin
            fwd_hit = b_pend_we_ff && (b_pend_waddr_ff == head_ff);
         end else if (d_src == SRC_COMP) begin
            fwd_hit = b_comp_we_ff && (b_comp_waddr_ff == comp_raddr);
         end
      end
   end

   always_comb begin
      b_read_val = (b_src_ff == SRC_PEND) ? pend_rd_data : comp_rd_data;
      if (b_fwd_ff) begin
         b_read_val = b_fwd_data_ff;
      end
      case (b_src_ff)
         SRC_NONE: b_moved = '0;
         SRC_REQ:  b_moved = b_req_entry_ff;
         SRC_PEND: b_moved = b_read_val;
         SRC_COMP: b_moved = b_read_val;
         default:  b_moved = '0;
      endcase
   end

   pqus_ram #(
      .DEPTH(PENDING_DEPTH),
      .WIDTH(EW),
      .AW(PAW)
   ) u_pending_ram (
      .clock  (clock),
      .wr_en  (b_adv && b_pend_we_ff),
      .wr_addr(b_pend_waddr_ff),
      .wr_data(b_moved),
      .rd_en  (accept),
      .rd_addr(head_ff),
      .rd_data(pend_rd_data)
   );

   pqus_ram #(
      .DEPTH(COMPLETED_DEPTH),
      .WIDTH(EW),
      .AW(CAW)
   ) u_completed_ram (
      .clock  (clock),
      .wr_en  (b_adv && b_comp_we_ff),
      .wr_addr(b_comp_waddr_ff),
      .wr_data(b_moved),
      .rd_en  (accept),
      .rd_addr(comp_raddr),
      .rd_data(comp_rd_data)
   );

   always_comb begin
      b_valid_in = b_valid_ff;
      if (accept) begin
         b_valid_in = 1'b1;
      end else if (b_adv) begin
         b_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         pocc_ff <= '0;
         cocc_ff <= '0;
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
         if (accept) begin
            head_ff <= head_in;
            pocc_ff <= pocc_in;
            cocc_ff <= cocc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_status_ff <= d_status;
         b_src_ff <= d_src;
         b_req_entry_ff <= {in_prio, in_tag};
         b_pend_we_ff <= d_pend_we;
         b_pend_waddr_ff <= d_pend_waddr;
         b_comp_we_ff <= d_comp_we;
         b_comp_waddr_ff <= d_comp_waddr;
         b_fwd_ff <= fwd_hit;
         b_fwd_data_ff <= b_moved;
         b_pocc_ff <= pocc_in;
         b_cocc_ff <= cocc_in;
      end
   end

   assign moved_tag_trim = b_moved[TAG_BITS-1:0];
   assign out_tag_wide = 32'(moved_tag_trim);
   assign out_pcount_wide = 32'(b_pocc_ff);
   assign out_ccount_wide = 32'(b_cocc_ff);

   always_comb begin
      o_data_in = {
         {RSP_PAD_W{1'b0}},
         out_ccount_wide[COUNT_W-1:0],
         out_pcount_wide[COUNT_W-1:0],
         b_moved[EW-1:TAG_BITS],
         out_tag_wide[TAG_W-1:0],
         b_status_ff
      };
   end

   always_comb begin
      o_valid_in = o_valid_ff;
      if (b_adv) begin
         o_valid_in = 1'b1;
      end else if (rsp_tready) begin
         o_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else begin
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_adv) begin
         o_data_ff <= o_data_in;
      end
   end

   assign rsp_tvalid = o_valid_ff;
   assign rsp_tdata = o_data_ff;

endmodule

>>> src/pqus_checker.sv
module pqus_checker
   import pqus_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic       req_beat;
   logic       rsp_beat;
   logic [1:0] inflight_ff, inflight_in;
   logic [COUNT_W-1:0] last_pcount_ff;
   logic [COUNT_W-1:0] last_ccount_ff;
   logic [COUNT_W-1:0] rsp_pcount;
   logic [COUNT_W-1:0] rsp_ccount;
   logic [STATUS_W-1:0] rsp_status;

   assign req_beat = req_tvalid && req_tready;
   assign rsp_beat = rsp_tvalid && rsp_tready;
   assign rsp_pcount = rsp_tdata[RSP_PCOUNT_LSB +: COUNT_W];
   assign rsp_ccount = rsp_tdata[RSP_CCOUNT_LSB +: COUNT_W];
   assign rsp_status = rsp_tdata[RSP_STATUS_LSB +: STATUS_W];

   always_comb begin
      inflight_in = inflight_ff;
      if (req_beat && !rsp_beat) begin
         inflight_in = inflight_ff + 2'd1;
      end else if (rsp_beat && !req_beat) begin
         inflight_in = inflight_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
         last_pcount_ff <= '0;
         last_ccount_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
         if (rsp_beat) begin
            last_pcount_ff <= rsp_pcount;
            last_ccount_ff <= rsp_ccount;
         end
      end
   end

   // A result beat held back must not change.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // The block only refuses a request when a result is waiting downstream.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("request side stalled without a stalled result");

   // At most two beats are held between the two channels.
   a_inflight_cap: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= 2'd2)
      else $error("more beats held than the pipeline has room for");

   // A result is never shown without a request beat behind it.
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (inflight_ff != 2'd0))
      else $error("result beat without a matching request beat");

   // A refused command leaves both occupancy counts where they were.
   a_error_no_change: assert property (@(posedge clock) disable iff (reset)
      (rsp_beat && (rsp_status != ST_OK)) |->
         ((rsp_pcount == last_pcount_ff) && (rsp_ccount == last_ccount_ff)))
      else $error("refused command changed an occupancy count");

endmodule

bind pending_queue_with_undo_stack pqus_checker u_pqus_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;
   import pqus_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 1850;
   localparam int HOLD_AFTER = 300;
   localparam int LONG_HOLD_CYCLES = 160;
   localparam int DRAIN_CYCLES = 10;
   localparam int CYCLE_LIMIT = 500000;
   localparam int PRINT_CAP = 40;

   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic [PRIO_W-1:0] prio;
   } task_entry_type;

   typedef struct packed {
      status_type         status;
      logic [TAG_W-1:0]   tag;
      logic [PRIO_W-1:0]  prio;
      logic [COUNT_W-1:0] pend_cnt;
      logic [COUNT_W-1:0] comp_cnt;
   } outcome_type;

   // Known is set when the row carries a hand-written outcome.
   typedef struct packed {
      logic              known;
      logic [OP_W-1:0]   op;
      logic [TAG_W-1:0]  tag;
      logic [PRIO_W-1:0] prio;
      outcome_type       want;
   } beat_note_type;

   typedef enum int {PH_FILL, PH_DRAIN, PH_UNWIND, PH_MIXED} phase_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // Shadow copy of the deque and the undo stack.
   task_entry_type deque_mem [DEF_PENDING_DEPTH];
   task_entry_type stack_mem [DEF_COMPLETED_DEPTH];
   int deque_head = 0;
   int deque_count = 0;
   int stack_count = 0;

   outcome_type   predicted_outcomes[$];
   beat_note_type offered_notes[$];
   int mismatch_count = 0;
   int accepted_count = 0;
   int cycle_count = 0;
   bit long_hold_done = 0;
   bit no_gaps = 0;

   pending_queue_with_undo_stack u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 25);
   endfunction

   function automatic outcome_type step_task_lists(input logic [OP_W-1:0] op,
                                                   input logic [TAG_W-1:0] tag,
                                                   input logic [PRIO_W-1:0] prio);
      outcome_type    o;
      task_entry_type moved;
      o = '0;
      o.status = ST_OK;
      moved = '0;
      if (op == OP_ADD) begin
         if (prio > MAX_PRIORITY) begin
            o.status = ST_BAD_PRIORITY;
         end else if (deque_count >= DEF_PENDING_DEPTH) begin
            o.status = ST_DEQUE_FULL;
         end else begin
            moved.tag = tag;
            moved.prio = prio;
            deque_mem[(deque_head + deque_count) % DEF_PENDING_DEPTH] = moved;
            deque_count++;
         end
      end else if (op == OP_PROCESS) begin
         if (deque_count == 0) begin
            o.status = ST_DEQUE_EMPTY;
         end else if (stack_count >= DEF_COMPLETED_DEPTH) begin
            // The entry stays at the front of the deque rather than being lost.
            o.status = ST_STACK_FULL;
         end else begin
            moved = deque_mem[deque_head];
            deque_head = (deque_head + 1) % DEF_PENDING_DEPTH;
            deque_count--;
            stack_mem[stack_count] = moved;
            stack_count++;
         end
      end else if (op == OP_UNDO) begin
         if (stack_count == 0) begin
            o.status = ST_STACK_EMPTY;
         end else if (deque_count >= DEF_PENDING_DEPTH) begin
            o.status = ST_DEQUE_FULL;
         end else begin
            stack_count--;
            moved = stack_mem[stack_count];
            deque_head = (deque_head + DEF_PENDING_DEPTH - 1) % DEF_PENDING_DEPTH;
            deque_mem[deque_head] = moved;
            deque_count++;
         end
      end
      o.tag = moved.tag;
      o.prio = moved.prio;
      o.pend_cnt = COUNT_W'(deque_count);
      o.comp_cnt = COUNT_W'(stack_count);
      return o;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatch_count < PRINT_CAP) begin
         $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      end
      mismatch_count++;
   endtask

   function automatic beat_note_type make_row(input int known, input logic [OP_W-1:0] op,
                                              input logic [TAG_W-1:0] tag,
                                              input logic [PRIO_W-1:0] prio,
                                              input status_type st,
                                              input int mtag,
                                              input int mprio,
                                              input int pc, input int cc);
      beat_note_type n;
      n.known = (known != 0);
      n.op = op;
      n.tag = tag;
      n.prio = prio;
      n.want.status = st;
      n.want.tag = TAG_W'(mtag);
      n.want.prio = PRIO_W'(mprio);
      n.want.pend_cnt = COUNT_W'(pc);
      n.want.comp_cnt = COUNT_W'(cc);
      return n;
   endfunction

   // Offers one request beat and returns at the edge where it is taken.
   task automatic offer_beat(input beat_note_type note);
      logic [REQ_TDATA_W-1:0] beat;
      int gap;
      beat = '0;
      beat[REQ_OP_LSB +: OP_W] = note.op;
      beat[REQ_TAG_LSB +: TAG_W] = note.tag;
      beat[REQ_PRIO_LSB +: PRIO_W] = note.prio;
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      offered_notes.push_back(note);
      req_tvalid <= 1'b1;
      req_tdata <= beat;
      do @(posedge clock); while (!req_tready);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   always @(posedge clock) begin
      outcome_type   got;
      outcome_type   want;
      outcome_type   predicted;
      beat_note_type note;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.status = status_type'(rsp_tdata[RSP_STATUS_LSB +: STATUS_W]);
            got.tag = rsp_tdata[RSP_TAG_LSB +: TAG_W];
            got.prio = rsp_tdata[RSP_PRIO_LSB +: PRIO_W];
            got.pend_cnt = rsp_tdata[RSP_PCOUNT_LSB +: COUNT_W];
            got.comp_cnt = rsp_tdata[RSP_CCOUNT_LSB +: COUNT_W];
            if (predicted_outcomes.size() == 0) begin
               report_mismatch("result beat with nothing outstanding", 1, 0);
            end else begin
               want = predicted_outcomes.pop_front();
               if (got.status !== want.status)
                  report_mismatch("status", int'(got.status), int'(want.status));
               if (got.tag !== want.tag)
                  report_mismatch("moved_tag", int'(got.tag), int'(want.tag));
               if (got.prio !== want.prio)
                  report_mismatch("moved_priority", int'(got.prio), int'(want.prio));
               if (got.pend_cnt !== want.pend_cnt)
                  report_mismatch("pending_count", int'(got.pend_cnt),
                                  int'(want.pend_cnt));
               if (got.comp_cnt !== want.comp_cnt)
                  report_mismatch("completed_count", int'(got.comp_cnt),
                                  int'(want.comp_cnt));
            end
         end
         if (req_tvalid && req_tready) begin
            accepted_count++;
            if (offered_notes.size() == 0) begin
               report_mismatch("request beat taken without being offered", 1, 0);
            end else begin
               note = offered_notes.pop_front();
               predicted = step_task_lists(note.op, note.tag, note.prio);
               predicted_outcomes.push_back(note.known ? note.want : predicted);
            end
         end
      end
   end

   // Receiver: short random stalls, occasional clear stretches, and one long
   // hold-off that lets the block fill up and push back on the request side.
   initial begin
      int n;
      rsp_tready <= 1'b0;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (!long_hold_done && accepted_count >= HOLD_AFTER) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold_done = 1;
         end else if ($urandom_range(0, 99) < 5) begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(50, 150)) @(posedge clock);
         end else begin
            n = pick_gap();
            if (n == 0) begin
               rsp_tready <= 1'b1;
               repeat ($urandom_range(1, 6)) @(posedge clock);
            end else begin
               rsp_tready <= 1'b0;
               repeat (n) @(posedge clock);
            end
         end
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      beat_note_type rows[$];
      beat_note_type note;
      phase_type phase;
      int block_left;
      int counted;
      int r;
      logic [OP_W-1:0] op;
      logic [TAG_W-1:0] tag;
      logic [PRIO_W-1:0] prio;

      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      rows.push_back(make_row(1, OP_PROCESS, 16'h0000, 3'd0, ST_DEQUE_EMPTY, 0, 0, 0, 0));
      rows.push_back(make_row(1, OP_UNDO, 16'h0000, 3'd0, ST_STACK_EMPTY, 0, 0, 0, 0));
      rows.push_back(make_row(1, OP_ADD, 16'h1234, 3'd6, ST_BAD_PRIORITY, 0, 0, 0, 0));
      rows.push_back(make_row(1, OP_ADD, 16'hFFFF, 3'd7, ST_BAD_PRIORITY, 0, 0, 0, 0));
      rows.push_back(make_row(1, OP_ADD, 16'hFFFF, 3'd5, ST_OK, 16'hFFFF, 3'd5, 1, 0));
      rows.push_back(make_row(1, OP_ADD, 16'h0000, 3'd0, ST_OK, 16'h0000, 3'd0, 2, 0));
      rows.push_back(make_row(1, OP_UNUSED, 16'hABCD, 3'd7, ST_OK, 0, 0, 2, 0));
      rows.push_back(make_row(1, OP_ADD, 16'hAAAA, 3'd2, ST_OK, 16'hAAAA, 3'd2, 3, 0));
      rows.push_back(make_row(1, OP_ADD, 16'h5555, 3'd4, ST_OK, 16'h5555, 3'd4, 4, 0));
      rows.push_back(make_row(1, OP_PROCESS, 16'h0000, 3'd0, ST_OK, 16'hFFFF, 3'd5, 3, 1));
      rows.push_back(make_row(1, OP_PROCESS, 16'h0000, 3'd0, ST_OK, 16'h0000, 3'd0, 2, 2));
      rows.push_back(make_row(1, OP_UNDO, 16'h0000, 3'd0, ST_OK, 16'h0000, 3'd0, 3, 1));
      rows.push_back(make_row(1, OP_UNDO, 16'h0000, 3'd0, ST_OK, 16'hFFFF, 3'd5, 4, 0));
      rows.push_back(make_row(1, OP_UNDO, 16'h0000, 3'd0, ST_STACK_EMPTY, 0, 0, 4, 0));
      rows.push_back(make_row(0, OP_PROCESS, 16'h0000, 3'd0, ST_OK, 0, 0, 0, 0));
      rows.push_back(make_row(0, OP_PROCESS, 16'h0000, 3'd0, ST_OK, 0, 0, 0, 0));
      rows.push_back(make_row(0, OP_PROCESS, 16'h0000, 3'd0, ST_OK, 0, 0, 0, 0));
      rows.push_back(make_row(0, OP_PROCESS, 16'h0000, 3'd0, ST_OK, 0, 0, 0, 0));
      rows.push_back(make_row(1, OP_PROCESS, 16'h0000, 3'd0, ST_DEQUE_EMPTY, 0, 0, 0, 4));
      rows.push_back(make_row(0, OP_UNDO, 16'h0000, 3'd0, ST_OK, 0, 0, 0, 0));
      rows.push_back(make_row(0, OP_ADD, 16'h8001, 3'd3, ST_OK, 0, 0, 0, 0));
      rows.push_back(make_row(0, OP_ADD, 16'h7FFE, 3'd1, ST_OK, 0, 0, 0, 0));
      rows.push_back(make_row(0, OP_PROCESS, 16'h0000, 3'd0, ST_OK, 0, 0, 0, 0));
      foreach (rows[i]) offer_beat(rows[i]);

      // Random part in phases, so the deque and the stack both run full and empty.
      block_left = 0;
      counted = 0;
      phase = PH_MIXED;
      while (counted < RANDOM_ITEMS) begin
         if (block_left == 0) begin
            phase = phase_type'($urandom_range(0, 3));
            block_left = $urandom_range(40, 90);
            no_gaps = ($urandom_range(0, 3) == 0);
         end
         block_left--;
         r = $urandom_range(0, 99);
         case (phase)
            PH_FILL: begin
               op = (r < 75) ? OP_ADD : (r < 90) ? OP_PROCESS : OP_UNDO;
            end
            PH_DRAIN: begin
               op = (r < 75) ? OP_PROCESS : (r < 85) ? OP_ADD : OP_UNDO;
            end
            PH_UNWIND: begin
               op = (r < 70) ? OP_UNDO : (r < 85) ? OP_ADD : OP_PROCESS;
            end
            default: begin
               op = (r < 34) ? OP_ADD : (r < 67) ? OP_PROCESS : OP_UNDO;
            end
         endcase
         if ($urandom_range(0, 99) < 3) op = OP_UNUSED;
         r = $urandom_range(0, 9);
         tag = (r == 0) ? 16'hFFFF : (r == 1) ? 16'h0000 : TAG_W'($urandom_range(0, 65535));
         prio = ($urandom_range(0, 99) < 15) ? PRIO_W'($urandom_range(6, 7))
                                             : PRIO_W'($urandom_range(0, 5));
         note = make_row(0, op, tag, prio, ST_OK, 0, 0, 0, 0);
         offer_beat(note);
         if (op != OP_UNUSED) counted++;
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (predicted_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
src/pqus_pkg.sv
src/pqus_ram.sv
src/pending_queue_with_undo_stack.sv
src/pqus_checker.sv
verif/tb.sv
